>>> src/uxnc_pkg.sv
// ----------------------------------------------------------------------------
// uxnc_pkg
// byte masks, sequence length decode and xml name range tests for utf-8
// ----------------------------------------------------------------------------
package uxnc_pkg;

  localparam logic [7:0] Mask4Lead = 8'hFC;
  localparam logic [7:0] Mask3Lead = 8'hF0;
  localparam logic [7:0] Mask2Lead = 8'hE0;
  localparam logic [7:0] MaskCont  = 8'hC0;
  localparam logic [7:0] MaskAscii = 8'h80;

  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Code = 8'hF0;
  localparam logic [7:0] ContCode  = 8'h80;

  localparam logic [2:0] LenNone = 3'd0;
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenTwo  = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour = 3'd4;

  function automatic logic [2:0] seq_len(input logic [7:0] a);
    logic [2:0] n;
    if ((a & MaskAscii) == 8'h00) n = LenOne;
    else if ((a & Mask2Lead) == Lead2Code) n = LenTwo;
    else if ((a & Mask3Lead) == Lead3Code) n = LenThree;
    else if ((a & Mask4Lead) == Lead4Code) n = LenFour;
    else n = LenNone;
    return n;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & MaskCont) == ContCode;
  endfunction

  function automatic logic start1(input logic [7:0] a);
    return (a == 8'h5F) || (a inside {[8'h61:8'h7A]}) || (a inside {[8'h41:8'h5A]});
  endfunction

  function automatic logic extra1(input logic [7:0] a);
    return (a == 8'h2D) || (a == 8'h2E) || (a inside {[8'h30:8'h39]});
  endfunction

  function automatic logic start2(input logic [7:0] a, input logic [7:0] b);
    logic r;
    if (a == 8'hC3) r = (b <= 8'h96) || (b inside {[8'h98:8'hB6]}) || (b >= 8'hB8);
    else if (a inside {[8'hC4:8'hCB]}) r = 1'b1;
    else if (a == 8'hCD) r = (b inside {[8'hB0:8'hBD]}) || (b == 8'hBF);
    else r = (a inside {[8'hCE:8'hDF]});
    return r;
  endfunction

  function automatic logic extra2(input logic [7:0] a, input logic [7:0] b);
    logic r;
    if (a == 8'hC2) r = (b == 8'hB7);
    else if (a == 8'hCC) r = 1'b1;
    else if (a == 8'hCD) r = (b <= 8'hAF);
    else r = 1'b0;
    return r;
  endfunction

  function automatic logic start3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
    logic r;
    r = 1'b0;
    if (a == 8'hE0) begin
      r = (b >= 8'hA0);
    end else if (a == 8'hE1) begin
      r = 1'b1;
    end else if (a == 8'hE2) begin
      if (b == 8'h80) r = (c == 8'h8C) || (c == 8'h8D);
      else if (b == 8'h81) r = (c >= 8'hB0);
      else if (b inside {[8'h82:8'h85]}) r = 1'b1;
      else if (b == 8'h86) r = (c <= 8'h8F);
      else if (b inside {[8'hB0:8'hBE]}) r = 1'b1;
      else if (b == 8'hBF) r = (c <= 8'hAF);
    end else if (a == 8'hE3) begin
      r = (b != 8'h80) || (c >= 8'h81);
    end else if (a inside {[8'hE4:8'hEC]}) begin
      r = 1'b1;
    end else if (a == 8'hED) begin
      r = (b <= 8'h9F);
    end else if (a == 8'hEF) begin
      if (b inside {[8'hA4:8'hB6]}) r = 1'b1;
      else if (b == 8'hB7) r = (c <= 8'h8F) || (c >= 8'hB0);
      else if (b inside {[8'hB8:8'hBE]}) r = 1'b1;
      else if (b == 8'hBF) r = (c <= 8'hBD);
    end
    return r;
  endfunction

  function automatic logic extra3(input logic [7:0] a, input logic [7:0] b,
                                  input logic [7:0] c);
    return (a == 8'hE2) && (((b == 8'h80) && (c == 8'hBF)) ||
                            ((b == 8'h81) && (c == 8'h80)));
  endfunction

  function automatic logic any4(input logic [7:0] a, input logic [7:0] b);
    logic r;
    if (a == 8'hF0) r = (b >= 8'h90);
    else if ((a == 8'hF1) || (a == 8'hF2)) r = 1'b1;
    else if (a == 8'hF3) r = (b <= 8'hAF);
    else r = 1'b0;
    return r;
  endfunction

endpackage

>>> src/utf8_xml_name_char_classifier.sv
// ----------------------------------------------------------------------------
// utf8_xml_name_char_classifier
// classifies one utf-8 window as xml name start / name character
// ----------------------------------------------------------------------------
// usage:
//   a word (four window bytes and an available count) is taken at a rising
//   edge with start_i high and busy_o low; busy_o is always low, so a new
//   word can be issued every cycle.
//   each word gives one result: start_len_o and name_len_o are shown for
//   exactly one cycle while done_o is high, once the word has passed the
//   input register and then the result register.
//   throughput is one word per cycle; the decode and range tests are a
//   single pass of compare logic between the two registers.
//   a length of 0 means the character is rejected; truncated windows, bad
//   continuation bytes and bad lead bytes all give 0.
//   reset clears the pipeline valid flags; no result is in flight after it.
//   the receiver cannot stall: a result not taken in its cycle is gone.
// ----------------------------------------------------------------------------
module utf8_xml_name_char_classifier import uxnc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [7:0] lead_byte_i,
  input  logic [7:0] second_byte_i,
  input  logic [7:0] third_byte_i,
  input  logic [7:0] fourth_byte_i,
  input  logic [2:0] avail_count_i,
  output logic       done_o,
  output logic [2:0] start_len_o,
  output logic [2:0] name_len_o
);

  logic       in_vld_q;
  logic [7:0] a_q, b_q, c_q, d_q;
  logic [2:0] avail_q;

  logic       out_vld_q;
  logic [2:0] start_len_q, start_len_d;
  logic [2:0] name_len_q, name_len_d;

  logic [2:0] seq_n;
  logic [2:0] avail_sat;
  logic       st, nm;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= start_i;
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= lead_byte_i;
      b_q     <= second_byte_i;
      c_q     <= third_byte_i;
      d_q     <= fourth_byte_i;
      avail_q <= avail_count_i;
    end
    if (in_vld_q) begin
      start_len_q <= start_len_d;
      name_len_q  <= name_len_d;
    end
  end

  always_comb begin
    seq_n     = seq_len(a_q);
    // counts above four mean four or more
    avail_sat = (avail_q > LenFour) ? LenFour : avail_q;
    st = 1'b0;
    nm = 1'b0;
    if ((seq_n != LenNone) && (avail_sat >= seq_n)) begin
      case (seq_n)
        LenOne: begin
          st = start1(a_q);
          nm = st || extra1(a_q);
        end
        LenTwo: begin
          if (is_cont(b_q)) begin
            st = start2(a_q, b_q);
            nm = st || extra2(a_q, b_q);
          end
        end
        LenThree: begin
          if (is_cont(b_q) && is_cont(c_q)) begin
            st = start3(a_q, b_q, c_q);
            nm = st || extra3(a_q, b_q, c_q);
          end
        end
        LenFour: begin
          if (is_cont(b_q) && is_cont(c_q) && is_cont(d_q)) begin
            st = any4(a_q, b_q);
            nm = st;
          end
        end
        default: begin
          st = 1'b0;
          nm = 1'b0;
        end
      endcase
    end
    start_len_d = st ? seq_n : LenNone;
    name_len_d  = nm ? seq_n : LenNone;
  end

  assign done_o      = out_vld_q;
  assign start_len_o = start_len_q;
  assign name_len_o  = name_len_q;

`ifndef SYNTHESIS
  // every accepted word gives its result once it has passed the input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 done_o)
    else $error("result strobe missing two cycles after accept");

  // no strobe without a word taken into the input register before it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 2))
    else $error("result strobe without accepted word");

  // a name start character is always a name character of the same length
  a_start_in_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (start_len_o != LenNone) |-> (name_len_o == start_len_o))
    else $error("start length not matched by name length");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (name_len_o <= LenFour) && (start_len_o <= LenFour))
    else $error("length out of range");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the utf-8 xml name character classifier against a code point model
// ----------------------------------------------------------------------------
// every accepted window is decoded to a code point and matched against the
// xml 1.1 name start / name character ranges (no colon); the lengths that
// come out are queued and compared with each result strobe. a directed set
// covers the edge cases, then ~1900 random windows run under three sender
// idle settings.
// ----------------------------------------------------------------------------
module testbench;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic [7:0] lead_byte_i = 8'h00;
  logic [7:0] second_byte_i = 8'h00;
  logic [7:0] third_byte_i = 8'h00;
  logic [7:0] fourth_byte_i = 8'h00;
  logic [2:0] avail_count_i = 3'd0;
  logic       done_o;
  logic [2:0] start_len_o;
  logic [2:0] name_len_o;

  typedef struct packed {
    logic [2:0] start_len;
    logic [2:0] name_len;
  } char_lens_t;

  class name_char_scoreboard;
    char_lens_t lens_q[$];
    int         fails = 0;

    function bit xml_start_cp(int unsigned cp);
      return cp inside {32'h5F, [32'h41:32'h5A], [32'h61:32'h7A], [32'hC0:32'hD6],
                        [32'hD8:32'hF6], [32'hF8:32'h2FF], [32'h370:32'h37D],
                        [32'h37F:32'h1FFF], [32'h200C:32'h200D], [32'h2070:32'h218F],
                        [32'h2C00:32'h2FEF], [32'h3001:32'hD7FF], [32'hF900:32'hFDCF],
                        [32'hFDF0:32'hFFFD], [32'h10000:32'hEFFFF]};
    endfunction

    function bit xml_name_only_cp(int unsigned cp);
      return cp inside {32'h2D, 32'h2E, [32'h30:32'h39], 32'hB7, [32'h300:32'h36F],
                        [32'h203F:32'h2040]};
    endfunction

    // decode the window, reject overlong forms, then look up the ranges
    function char_lens_t classify(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic [7:0] b3, logic [2:0] avail);
      int unsigned len;
      int unsigned have;
      int unsigned cp;
      int unsigned min_cp;
      bit          ok;
      logic [7:0]  tail [3];
      char_lens_t  r;
      r = '0;
      len = 0;
      cp = 0;
      min_cp = 0;
      tail[0] = b1;
      tail[1] = b2;
      tail[2] = b3;
      have = (avail > 3'd4) ? 4 : 32'(avail);
      casez (b0)
        8'b0???????: begin
          len = 1;
          cp = 32'(b0[6:0]);
        end
        8'b110?????: begin
          len = 2;
          cp = 32'(b0[4:0]);
          min_cp = 32'h80;
        end
        8'b1110????: begin
          len = 3;
          cp = 32'(b0[3:0]);
          min_cp = 32'h800;
        end
        8'b111100??: begin
          len = 4;
          cp = 32'(b0[1:0]);
          min_cp = 32'h10000;
        end
        default: len = 0;
      endcase
      ok = (len != 0) && (have >= len);
      for (int i = 1; i < len; i++) begin
        ok = ok && (tail[i-1][7:6] == 2'b10);
        cp = (cp << 6) | 32'(tail[i-1][5:0]);
      end
      if (ok && cp >= min_cp) begin
        if (xml_start_cp(cp)) r.start_len = 3'(len);
        if (xml_start_cp(cp) || xml_name_only_cp(cp)) r.name_len = 3'(len);
      end
      return r;
    endfunction

    function void note_word(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                            logic [7:0] b3, logic [2:0] avail);
      lens_q.push_back(classify(b0, b1, b2, b3, avail));
    endfunction

    function void check_result(logic [2:0] start_len, logic [2:0] name_len);
      char_lens_t exp_lens;
      if (lens_q.size() == 0) begin
        $error("result with no word pending: start_len %0d name_len %0d",
               start_len, name_len);
        fails++;
        return;
      end
      exp_lens = lens_q.pop_front();
      if (start_len !== exp_lens.start_len) begin
        $error("start_len mismatch: expected %0d, got %0d", exp_lens.start_len, start_len);
        fails++;
      end
      if (name_len !== exp_lens.name_len) begin
        $error("name_len mismatch: expected %0d, got %0d", exp_lens.name_len, name_len);
        fails++;
      end
    endfunction

    function int pending();
      return lens_q.size();
    endfunction

    function void report_leftover();
      if (lens_q.size() != 0) begin
        $error("%0d expected result(s) never arrived", lens_q.size());
        fails++;
      end
    endfunction
  endclass

  name_char_scoreboard sb = new();
  int                  sender_idle_pct = 37;

  // range edges of the name tables, used to steer random code points
  int unsigned boundary_cps [$] = '{
    32'h2D, 32'h2F, 32'h30, 32'h39, 32'h3A, 32'h41, 32'h5A, 32'h5F, 32'h61, 32'h7A,
    32'h7F, 32'h80, 32'hB7, 32'hC0, 32'hD6, 32'hD8, 32'hF6, 32'hF8, 32'h2FF, 32'h300,
    32'h36F, 32'h370, 32'h37D, 32'h37F, 32'h7FF, 32'h800, 32'hFFF, 32'h1FFF, 32'h2000,
    32'h200C, 32'h200D, 32'h203F, 32'h2040, 32'h2070, 32'h218F, 32'h2C00, 32'h2FBF,
    32'h2FEF, 32'h3000, 32'h3001, 32'hD7FF, 32'hD800, 32'hDFFF, 32'hE000, 32'hF8FF,
    32'hF900, 32'hFDCF, 32'hFDF0, 32'hFFFD, 32'hFFFF, 32'h10000, 32'h3FFFF, 32'h40000,
    32'hBFFFF, 32'hC0000, 32'hEFFFF, 32'hF0000, 32'h10FFFF
  };

  utf8_xml_name_char_classifier u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .lead_byte_i   (lead_byte_i),
    .second_byte_i (second_byte_i),
    .third_byte_i  (third_byte_i),
    .fourth_byte_i (fourth_byte_i),
    .avail_count_i (avail_count_i),
    .done_o        (done_o),
    .start_len_o   (start_len_o),
    .name_len_o    (name_len_o)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(start_len_o, name_len_o);
      if (start_i && !busy_o) begin
        sb.note_word(lead_byte_i, second_byte_i, third_byte_i, fourth_byte_i,
                     avail_count_i);
      end
    end
  end

  // called right after a rising edge; returns at the edge that takes the word
  task automatic send_word(input logic [7:0] b0, input logic [7:0] b1,
                           input logic [7:0] b2, input logic [7:0] b3,
                           input logic [2:0] avail);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i       <= 1'b1;
    lead_byte_i   <= b0;
    second_byte_i <= b1;
    third_byte_i  <= b2;
    fourth_byte_i <= b3;
    avail_count_i <= avail;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic int unsigned encode_cp(input int unsigned cp, ref logic [7:0] w [4]);
    if (cp < 32'h80) begin
      w[0] = cp[7:0];
      return 1;
    end
    if (cp < 32'h800) begin
      w[0] = {3'b110, cp[10:6]};
      w[1] = {2'b10, cp[5:0]};
      return 2;
    end
    if (cp < 32'h10000) begin
      w[0] = {4'b1110, cp[15:12]};
      w[1] = {2'b10, cp[11:6]};
      w[2] = {2'b10, cp[5:0]};
      return 3;
    end
    w[0] = {5'b11110, cp[20:18]};
    w[1] = {2'b10, cp[17:12]};
    w[2] = {2'b10, cp[11:6]};
    w[3] = {2'b10, cp[5:0]};
    return 4;
  endfunction

  task automatic send_random();
    logic [7:0]  w [4];
    int unsigned len;
    int unsigned cp;
    int unsigned mode;
    logic [2:0]  avail;
    for (int i = 0; i < 4; i++) w[i] = 8'($urandom);
    mode = $urandom_range(0, 9);
    len = 1;
    if (mode <= 3) begin
      // code point at or next to a range edge
      cp = boundary_cps[$urandom_range(0, boundary_cps.size() - 1)];
      cp = cp + $urandom_range(0, 2);
      cp = (cp == 0) ? 0 : cp - 1;
      len = encode_cp(cp, w);
    end else if (mode <= 7) begin
      // well-formed shape, random payload bits
      len = $urandom_range(1, 4);
      case (len)
        1: w[0][7] = 1'b0;
        2: w[0][7:5] = 3'b110;
        3: w[0][7:4] = 4'b1110;
        default: w[0][7:2] = 6'b111100;
      endcase
      for (int i = 1; i < len; i++) w[i][7:6] = 2'b10;
      // now and then break one continuation byte
      if (len > 1 && $urandom_range(0, 9) == 0) w[$urandom_range(1, len - 1)][7:6] = 2'($urandom);
    end
    if (mode >= 8) avail = 3'($urandom);
    else if ($urandom_range(0, 7) == 0) avail = 3'($urandom_range(0, len - 1));
    else avail = 3'($urandom_range(len, 7));
    send_word(w[0], w[1], w[2], w[3], avail);
  endtask

  initial begin
    int wait_cycles;
    wait_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(8'h41, 8'h00, 8'h00, 8'h00, 3'd0); // empty window
    send_word(8'h7A, 8'hFF, 8'hFF, 8'hFF, 3'd7); // oversized count, junk tail
    send_word(8'h5F, 8'hC3, 8'hE2, 8'hF0, 3'd1);
    send_word(8'h3A, 8'h00, 8'h00, 8'h00, 3'd4); // colon left out
    send_word(8'h2D, 8'h00, 8'h00, 8'h00, 3'd1);
    send_word(8'h39, 8'h80, 8'h80, 8'h80, 3'd2);
    send_word(8'h00, 8'h00, 8'h00, 8'h00, 3'd1);
    send_word(8'h80, 8'h80, 8'h80, 8'h80, 3'd4); // continuation as lead
    send_word(8'hFF, 8'hBF, 8'hBF, 8'hBF, 3'd4);
    send_word(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
    send_word(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd2); // overlong two-byte
    send_word(8'hC2, 8'hB7, 8'h00, 8'h00, 3'd1); // truncated
    send_word(8'hC2, 8'hB7, 8'h00, 8'h00, 3'd2); // middle dot
    send_word(8'hC3, 8'h41, 8'h00, 8'h00, 3'd4); // bad continuation
    send_word(8'hCC, 8'h80, 8'hFF, 8'hFF, 3'd2);
    send_word(8'hCD, 8'hB0, 8'h00, 8'h00, 3'd5);
    send_word(8'hE0, 8'h80, 8'h80, 8'h00, 3'd3); // overlong three-byte
    send_word(8'hE2, 8'h80, 8'hBF, 8'h00, 3'd3);
    send_word(8'hE2, 8'h81, 8'h80, 8'h00, 3'd3);
    send_word(8'hE2, 8'h80, 8'h8C, 8'h00, 3'd6);
    send_word(8'hEF, 8'hBF, 8'hBD, 8'h00, 3'd3);
    send_word(8'hEF, 8'hBF, 8'hBE, 8'h00, 3'd3);
    send_word(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3); // surrogate
    send_word(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
    send_word(8'hF0, 8'h90, 8'h80, 8'h80, 3'd3); // truncated four-byte
    send_word(8'hF3, 8'hB0, 8'h80, 8'h80, 3'd7);
    send_word(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4); // overlong four-byte

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 77 : 0;
      repeat (642) send_random();
    end
    start_i <= 1'b0;

    while (sb.pending() != 0 && wait_cycles < 100) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    sb.report_leftover();
    if (sb.fails == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
